@@ sv/fbae_pkg.sv @@
package fbae_pkg;

    // Field widths
    localparam int IDX_W      = 12;
    localparam int SMP_W      = 24;
    localparam int LOG2_W     = 4;
    localparam int THR_W      = 23;
    localparam int RATE_W     = 18;
    localparam int FREQ_W     = 21;
    localparam int AMP_W      = 25;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;

    // Transform size limits
    localparam int MAX_SIZE = 4096;
    localparam int MAX_LOG2 = $clog2(MAX_SIZE + 1) - 1;

    // Register reset values
    localparam logic [LOG2_W-1:0] LOG2_RESET = LOG2_W'(10);
    localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(1);
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(44100);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOG2_SIZE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAG_THR     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = CFG_IDX_W'(2);

    // Datapath widths
    localparam int SQ_W      = 2 * SMP_W;          // re^2 + im^2 fits here
    localparam int TN_W      = THR_W + MAX_LOG2;   // threshold * N
    localparam int TN_MUL_W  = 32;                 // threshold * N kept below 2^32
    localparam int FPROD_W   = RATE_W + IDX_W;
    localparam int DC_AMP_W  = SMP_W - 1;
    localparam int RAD_W     = SQ_W + 2;           // 4 * (re^2 + im^2)
    localparam int ROOT_W    = RAD_W / 2;
    localparam int REM_W     = ROOT_W + 3;

    // Square root pipeline
    localparam int SQRT_PER_STAGE = 5;
    localparam int SQRT_STAGES    = ROOT_W / SQRT_PER_STAGE;

    // Item information carried alongside the square root
    typedef struct packed {
        logic                keep;
        logic                is_dc;
        logic [FREQ_W-1:0]   freq;
        logic [DC_AMP_W-1:0] dc_amp;
    } t_side;

    // Clamp the size register to the supported range
    function automatic logic [LOG2_W-1:0] eff_log2(input logic [LOG2_W-1:0] v);
        logic [LOG2_W-1:0] k;
        k = v;
        if (k < LOG2_W'(1)) begin
            k = LOG2_W'(1);
        end
        if (k > LOG2_W'(MAX_LOG2)) begin
            k = LOG2_W'(MAX_LOG2);
        end
        return k;
    endfunction

endpackage

@@ sv/fbae_sqrt_pipe.sv @@
module fbae_sqrt_pipe
    import fbae_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [RAD_W-1:0]  i_rad,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output t_side             o_side
);

    logic              r_valid [SQRT_STAGES];
    logic [REM_W-1:0]  r_rem   [SQRT_STAGES];
    logic [ROOT_W-1:0] r_root  [SQRT_STAGES];
    logic [RAD_W-1:0]  r_rad   [SQRT_STAGES];
    t_side             r_side  [SQRT_STAGES];

    logic              n_valid [SQRT_STAGES];
    logic [REM_W-1:0]  n_rem   [SQRT_STAGES];
    logic [ROOT_W-1:0] n_root  [SQRT_STAGES];
    logic [RAD_W-1:0]  n_rad   [SQRT_STAGES];
    t_side             n_side  [SQRT_STAGES];

    // Each stage resolves SQRT_PER_STAGE root bits, restoring digit by digit
    always_comb begin
        logic [REM_W-1:0]  rem;
        logic [REM_W-1:0]  trial;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
        for (int s = 0; s < SQRT_STAGES; s++) begin
            if (s == 0) begin
                n_valid[s] = i_valid;
                n_side[s]  = i_side;
                rem        = '0;
                root       = '0;
                rad        = i_rad;
            end else begin
                n_valid[s] = r_valid[s-1];
                n_side[s]  = r_side[s-1];
                rem        = r_rem[s-1];
                root       = r_root[s-1];
                rad        = r_rad[s-1];
            end
            for (int j = 0; j < SQRT_PER_STAGE; j++) begin
                rem   = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
                rad   = rad << 2;
                trial = {1'b0, root, 2'b01};
                if (rem >= trial) begin
                    rem  = rem - trial;
                    root = {root[ROOT_W-2:0], 1'b1};
                end else begin
                    root = {root[ROOT_W-2:0], 1'b0};
                end
            end
            n_rem[s]  = rem;
            n_root[s] = root;
            n_rad[s]  = rad;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < SQRT_STAGES; s++) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else begin
                r_valid[s] <= n_valid[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < SQRT_STAGES; s++) begin
            r_rem[s]  <= n_rem[s];
            r_root[s] <= n_root[s];
            r_rad[s]  <= n_rad[s];
            r_side[s] <= n_side[s];
        end
    end

    assign o_valid = r_valid[SQRT_STAGES-1];
    assign o_root  = r_root[SQRT_STAGES-1];
    assign o_side  = r_side[SQRT_STAGES-1];

endmodule

@@ sv/fft_bin_amplitude_extractor.sv @@
// FFT bin amplitude extractor: turns a stream of complex FFT bins into a
// thresholded magnitude spectrum.
//
// Input: one bin per transfer on i_bin_index / i_bin_real / i_bin_imag,
// taken at a rising edge with start high and busy low. busy is always low,
// so a bin can be transferred on every clock cycle.
// Output: each reported bin appears on o_frequency / o_amplitude / o_is_dc
// for exactly one cycle with o_result_valid high. A bin gives at most one
// result; bins outside the band or below the threshold give none.
// Pipeline: ten register stages (capture, stages 1 to 3, five square root
// stages, output register), in that order. Throughput: one bin per cycle;
// the five-stage square root resolves five root bits per stage.
// Configuration: i_cfg_we / i_cfg_index / i_cfg_data write log2_size (0),
// magnitude_threshold (1) and sample_rate (2); write only while no bin is
// in flight.
// Reset: synchronous, active low; empties the pipeline and loads the
// register defaults (N = 1024, threshold 1, 44100 Hz).
// The receiver cannot stall: results are never held back.
module fft_bin_amplitude_extractor
    import fbae_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [IDX_W-1:0]      i_bin_index,
    input  logic [SMP_W-1:0]      i_bin_real,
    input  logic [SMP_W-1:0]      i_bin_imag,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_result_valid,
    output logic [FREQ_W-1:0]     o_frequency,
    output logic [AMP_W-1:0]      o_amplitude,
    output logic                  o_is_dc
);

    localparam int PIPE_REGS = 4 + SQRT_STAGES + 1;

    // Configuration registers
    logic [LOG2_W-1:0] r_log2_size;
    logic [THR_W-1:0]  r_mag_thr;
    logic [RATE_W-1:0] r_sample_rate;
    logic [LOG2_W-1:0] w_k;

    // Stage A: captured bin
    logic                    r_a_valid;
    logic [IDX_W-1:0]        r_a_idx;
    logic signed [SMP_W-1:0] r_a_re;
    logic signed [SMP_W-1:0] r_a_im;

    // Stage 1: squares, scaled threshold, classification
    logic signed [SQ_W-1:0] w_sq_re;
    logic signed [SQ_W-1:0] w_sq_im;
    logic [TN_W-1:0]        w_tn;
    logic                   w_in_band;
    logic [DC_AMP_W-1:0]    w_dc_amp;
    logic                   r1_valid;
    logic [SQ_W-1:0]        r1_sq_re;
    logic [SQ_W-1:0]        r1_sq_im;
    logic [TN_MUL_W-1:0]    r1_tn;
    logic                   r1_is_dc;
    logic                   r1_dc_pass;
    logic                   r1_band_ok;
    logic [DC_AMP_W-1:0]    r1_dc_amp;
    logic [FPROD_W-1:0]     r1_fprod;

    // Stage 2: magnitude squared, threshold squared, frequency
    logic [FPROD_W+3:0]      w_freq_full;
    logic                    r2_valid;
    logic [SQ_W-1:0]         r2_mag2;
    logic [2*TN_MUL_W-1:0]   r2_tn2;
    logic                    r2_is_dc;
    logic                    r2_dc_pass;
    logic                    r2_band_ok;
    logic [DC_AMP_W-1:0]     r2_dc_amp;
    logic [FREQ_W-1:0]       r2_freq;

    // Stage 3: decision and radicand
    t_side             n3_side;
    logic              r3_valid;
    logic [RAD_W-1:0]  r3_rad;
    t_side             r3_side;

    // Square root outputs
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    t_side             sq_side;
    logic [AMP_W-1:0]  w_amp;

    // Output registers
    logic              r_out_valid;
    logic [FREQ_W-1:0] r_out_freq;
    logic [AMP_W-1:0]  r_out_amp;
    logic              r_out_is_dc;

    // The pipeline takes a transfer every cycle
    assign busy = 1'b0;

    // Configuration writes; an unused index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2_size   <= LOG2_RESET;
            r_mag_thr     <= THR_RESET;
            r_sample_rate <= RATE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LOG2_SIZE:   r_log2_size   <= i_cfg_data[LOG2_W-1:0];
                CFG_MAG_THR:     r_mag_thr     <= i_cfg_data[THR_W-1:0];
                CFG_SAMPLE_RATE: r_sample_rate <= i_cfg_data[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // User keeps registers still while bins are in flight (unchecked); every stage reads them live
    assign w_k = eff_log2(r_log2_size);

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_a_valid   <= start && !busy;
            r1_valid    <= r_a_valid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r_out_valid <= sq_valid && sq_side.keep;
        end
    end

    // Stage A: capture the bin
    always_ff @(posedge i_clk) begin
        r_a_idx <= i_bin_index;
        r_a_re  <= i_bin_real;
        r_a_im  <= i_bin_imag;
    end

    // Stage 1: square both parts, scale the threshold by N
    assign w_sq_re   = SQ_W'(r_a_re) * SQ_W'(r_a_re);
    assign w_sq_im   = SQ_W'(r_a_im) * SQ_W'(r_a_im);
    assign w_tn      = {{MAX_LOG2{1'b0}}, r_mag_thr} << w_k;
    // In band when the index is below N/2
    assign w_in_band = (r_a_idx >> (w_k - LOG2_W'(1))) == '0;
    assign w_dc_amp  = r_a_re[DC_AMP_W-1:0] >> w_k;

    always_ff @(posedge i_clk) begin
        r1_sq_re   <= unsigned'(w_sq_re);
        r1_sq_im   <= unsigned'(w_sq_im);
        r1_tn      <= w_tn[TN_MUL_W-1:0];
        r1_is_dc   <= r_a_idx == '0;
        r1_dc_pass <= r_a_re >= $signed({1'b0, r_mag_thr});
        // Drop non-DC bins whose scaled threshold reaches 2^32: nothing can pass
        r1_band_ok <= w_in_band && (w_tn[TN_W-1:TN_MUL_W] == '0);
        r1_dc_amp  <= w_dc_amp;
        r1_fprod   <= FPROD_W'(r_sample_rate) * FPROD_W'(r_a_idx);
    end

    // Stage 2: sum of squares, threshold squared, frequency in 1/16 Hz
    assign w_freq_full = {r1_fprod, 4'b0000} >> w_k;

    always_ff @(posedge i_clk) begin
        r2_mag2    <= r1_sq_re + r1_sq_im;
        r2_tn2     <= (2*TN_MUL_W)'(r1_tn) * (2*TN_MUL_W)'(r1_tn);
        r2_is_dc   <= r1_is_dc;
        r2_dc_pass <= r1_dc_pass;
        r2_band_ok <= r1_band_ok;
        r2_dc_amp  <= r1_dc_amp;
        // Below sample_rate * 8 for any in-band bin, so the field never overflows
        r2_freq    <= w_freq_full[FREQ_W-1:0];
    end

    // Stage 3: decide whether the bin is reported, form 4 * |X|^2
    always_comb begin
        n3_side.is_dc  = r2_is_dc;
        n3_side.dc_amp = r2_dc_amp;
        n3_side.freq   = r2_is_dc ? '0 : r2_freq;
        if (r2_is_dc) begin
            n3_side.keep = r2_dc_pass;
        end else begin
            n3_side.keep = r2_band_ok &&
                ({{(2*TN_MUL_W-SQ_W){1'b0}}, r2_mag2} >= r2_tn2);
        end
    end

    always_ff @(posedge i_clk) begin
        r3_rad  <= {r2_mag2, 2'b00};
        r3_side <= n3_side;
    end

    fbae_sqrt_pipe u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_valid),
        .i_rad   (r3_rad),
        .i_side  (r3_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // isqrt(4|X|^2) / N never exceeds the amplitude field
    assign w_amp = sq_root >> w_k;

    // Output stage: pick the DC or the magnitude amplitude
    always_ff @(posedge i_clk) begin
        r_out_freq  <= sq_side.freq;
        r_out_is_dc <= sq_side.is_dc;
        if (sq_side.is_dc) begin
            r_out_amp <= {{(AMP_W-DC_AMP_W){1'b0}}, sq_side.dc_amp};
        end else begin
            r_out_amp <= w_amp;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_frequency    = r_out_freq;
    assign o_amplitude    = r_out_amp;
    assign o_is_dc        = r_out_is_dc;

    // A result always stems from an earlier bin transfer
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && i_rst_n, PIPE_REGS))
        else $error("result without a matching input transfer");

    // A non-DC result lies below the Nyquist frequency
    a_freq_below_nyquist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_is_dc) |->
            ((o_frequency < ({3'b000, r_sample_rate} << 3)) || (o_frequency == '0)))
        else $error("bin frequency at or above Nyquist");

    // A DC result carries zero frequency and an amplitude no wider than the input
    a_dc_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_is_dc) |->
            ((o_frequency == '0) && (o_amplitude[AMP_W-1:DC_AMP_W] == '0)))
        else $error("malformed DC result");

endmodule

@@ verif/tb_fft_bin_amplitude_extractor.sv @@
module tb_fft_bin_amplitude_extractor
    import fbae_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Ten register stages inside the block; leave a margin before touching
    // the registers or ending the run, since a bin may give no line at all.
    localparam int PIPE_GUARD  = 16;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [63:0] AMP_TOP  = (64'd1 << AMP_W) - 64'd1;
    localparam logic [63:0] FREQ_TOP = (64'd1 << FREQ_W) - 64'd1;
    localparam longint SMP_MAX = 64'sd8388607;
    localparam longint SMP_MIN = -64'sd8388608;

    // One reported spectral line as it leaves the block.
    typedef struct {
        logic [FREQ_W-1:0] freq;
        logic [AMP_W-1:0]  amp;
        logic              dc;
    } t_spectral_line;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [IDX_W-1:0]      i_bin_index = '0;
    logic [SMP_W-1:0]      i_bin_real = '0;
    logic [SMP_W-1:0]      i_bin_imag = '0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_result_valid;
    logic [FREQ_W-1:0]     o_frequency;
    logic [AMP_W-1:0]      o_amplitude;
    logic                  o_is_dc;

    // Shadow of the register file, updated as each write lands.
    logic [LOG2_W-1:0] cur_log2 = LOG2_RESET;
    logic [THR_W-1:0]  cur_thr  = THR_RESET;
    logic [RATE_W-1:0] cur_rate = RATE_RESET;

    t_spectral_line expected_lines[$];

    int unsigned mismatches = 0;
    int unsigned bins_sent = 0;
    int unsigned lines_checked = 0;
    int unsigned settings_applied = 0;
    int unsigned burst_left = 0;
    int unsigned cycle_count = 0;

    fft_bin_amplitude_extractor dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_bin_index    (i_bin_index),
        .i_bin_real     (i_bin_real),
        .i_bin_imag     (i_bin_imag),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_frequency    (o_frequency),
        .o_amplitude    (o_amplitude),
        .o_is_dc        (o_is_dc)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Clamp the size register the way the block does: below 1 acts as 1,
    // above the largest supported size acts as that size.
    function automatic int unsigned eff_size_log2();
        int unsigned k;
        k = cur_log2;
        if (k < 1) begin
            k = 1;
        end
        if (k > MAX_LOG2) begin
            k = MAX_LOG2;
        end
        return k;
    endfunction

    // Digit-by-digit integer square root, rounded down.
    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] trial;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = r | (64'd1 << b);
            if (trial * trial <= v) begin
                r = trial;
            end
        end
        return r;
    endfunction

    // Work out the line one bin gives under the current registers.
    // Return 0 when the bin is out of band or below threshold.
    function automatic bit predict_line(input logic [IDX_W-1:0] idx,
                                        input logic signed [SMP_W-1:0] re,
                                        input logic signed [SMP_W-1:0] im,
                                        output t_spectral_line spec);
        int unsigned k;
        longint      re_v;
        longint      im_v;
        logic [63:0] mag2;
        logic [63:0] thr_n;
        logic [63:0] amp;
        logic [63:0] freq;
        k = eff_size_log2();
        re_v = re;
        im_v = im;
        spec.freq = '0;
        spec.amp = '0;
        spec.dc = 1'b0;

        // DC: a plain compare of the real part, then divide by N.
        if (idx == '0) begin
            if (re_v < longint'(cur_thr)) begin
                return 1'b0;
            end
            amp = 64'(re_v) >> k;
            spec.amp = (amp > AMP_TOP) ? AMP_TOP[AMP_W-1:0] : amp[AMP_W-1:0];
            spec.dc = 1'b1;
            return 1'b1;
        end

        // Drop anything at or above the Nyquist bin.
        if (64'(idx) >= (64'd1 << (k - 1))) begin
            return 1'b0;
        end

        // Compare squared magnitudes; a threshold*N of 2^32 or more blocks all.
        mag2 = 64'(re_v * re_v) + 64'(im_v * im_v);
        thr_n = 64'(cur_thr) << k;
        if (thr_n >= (64'd1 << 32)) begin
            return 1'b0;
        end
        if (mag2 < thr_n * thr_n) begin
            return 1'b0;
        end

        amp = floor_root(mag2 << 2) >> k;
        freq = (64'(cur_rate) * 64'(idx) * 64'd16) >> k;
        spec.amp = (amp > AMP_TOP) ? AMP_TOP[AMP_W-1:0] : amp[AMP_W-1:0];
        spec.freq = (freq > FREQ_TOP) ? FREQ_TOP[FREQ_W-1:0] : freq[FREQ_W-1:0];
        return 1'b1;
    endfunction

    function automatic logic [SMP_W-1:0] clip_sample(input longint v);
        if (v > SMP_MAX) begin
            v = SMP_MAX;
        end
        if (v < SMP_MIN) begin
            v = SMP_MIN;
        end
        return v[SMP_W-1:0];
    endfunction

    // Sender idle gaps: mostly random, with occasional back-to-back bursts.
    function automatic int unsigned next_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    // Send one bin and, once the transfer happens, queue its expected line.
    // Leave start high afterwards so a zero gap gives back-to-back transfers.
    task automatic send_bin(input logic [IDX_W-1:0] idx,
                            input logic [SMP_W-1:0] re,
                            input logic [SMP_W-1:0] im);
        int unsigned    gap;
        t_spectral_line spec;
        gap = next_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_bin_index <= idx;
        i_bin_real <= re;
        i_bin_imag <= im;
        do @(posedge i_clk); while (busy !== 1'b0);
        bins_sent++;
        if (predict_line(idx, re, im, spec)) begin
            expected_lines.push_back(spec);
        end
    endtask

    // Hold the sender off until every queued line has come out.
    task automatic wait_for_drain();
        start <= 1'b0;
        do @(posedge i_clk); while (expected_lines.size() != 0);
    endtask

    // Drain, then give bins that report nothing time to leave the pipe.
    task automatic settle_pipeline();
        wait_for_drain();
        repeat (PIPE_GUARD) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (sel)
            CFG_LOG2_SIZE:   cur_log2 = value[LOG2_W-1:0];
            CFG_MAG_THR:     cur_thr = value[THR_W-1:0];
            CFG_SAMPLE_RATE: cur_rate = value[RATE_W-1:0];
            default: ;
        endcase
    endtask

    // Reprogram all three registers with the pipe empty.
    task automatic apply_settings(input logic [LOG2_W-1:0] log2_val,
                                  input logic [THR_W-1:0] thr_val,
                                  input logic [RATE_W-1:0] rate_val);
        settle_pipeline();
        write_reg(CFG_LOG2_SIZE, CFG_DATA_W'(log2_val));
        write_reg(CFG_MAG_THR, CFG_DATA_W'(thr_val));
        write_reg(CFG_SAMPLE_RATE, CFG_DATA_W'(rate_val));
        i_cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // Reset registers (N = 1024, threshold 1): DC sign and threshold edges,
    // the exact in-band threshold, top of band, beyond the band.
    task automatic test_band_edges();
        send_bin(12'd0, 24'h7FFFFF, 24'h000000);
        send_bin(12'd0, 24'h800000, 24'h7FFFFF);
        send_bin(12'd0, 24'h000001, 24'hFFFFFF);
        send_bin(12'd0, 24'h000000, 24'h000000);
        send_bin(12'd1, 24'h000400, 24'h000000);
        send_bin(12'd1, 24'h0003FF, 24'h000000);
        send_bin(12'd511, 24'h800000, 24'h800000);
        send_bin(12'd300, 24'h800000, 24'h7FFFFF);
        send_bin(12'd512, 24'h7FFFFF, 24'h7FFFFF);
        send_bin(12'd4095, 24'h0186A0, 24'h0186A0);
    endtask

    // Register extremes: size below and above range, zero and huge
    // threshold, zero and top sample rate.
    task automatic test_config_extremes();
        apply_settings(4'd0, 23'd0, 18'd0);
        send_bin(12'd0, 24'h000000, 24'h000000);
        send_bin(12'd1, 24'h000005, 24'h000005);
        send_bin(12'd0, 24'hFFFFFF, 24'h000000);

        apply_settings(4'd15, 23'h7FFFFF, 18'h3FFFF);
        send_bin(12'd2047, 24'h7FFFFF, 24'h7FFFFF);
        send_bin(12'd0, 24'h7FFFFF, 24'h000000);
        send_bin(12'd0, 24'h7FFFFE, 24'h000000);

        apply_settings(4'd12, 23'd0, 18'h3FFFF);
        send_bin(12'd2047, 24'h000000, 24'h000000);
        send_bin(12'd2048, 24'h000001, 24'h000001);

        apply_settings(4'd1, 23'd1, 18'd1);
        send_bin(12'd0, 24'h000002, 24'h123456);

        // threshold * N lands exactly on 2^32
        apply_settings(4'd10, 23'h400000, 18'd192000);
        send_bin(12'd5, 24'h800000, 24'h800000);
        send_bin(12'd0, 24'h400000, 24'h000000);
    endtask

    // Random bins over ten register settings; most bins sit in band and
    // many near the threshold so that both outcomes show up often.
    task automatic test_random_sweep();
        int unsigned log2_plan[10] = '{1, 12, 0, 15, 5, 9, 10, 3, 7, 11};
        int unsigned rate_picks[4] = '{0, 262143, 1, 44100};
        int unsigned k;
        int unsigned half;
        int unsigned pick;
        logic [IDX_W-1:0] idx;
        logic [THR_W-1:0] thr;
        logic [RATE_W-1:0] rate;
        longint target;
        longint a;
        longint b;
        for (int p = 0; p < 10; p++) begin
            case (p % 4)
                0: thr = THR_W'($urandom_range(0, 3));
                1: thr = THR_W'($urandom_range(0, 2000));
                2: thr = '0;
                default: thr = THR_W'($urandom);
            endcase
            case (p % 3)
                0: rate = RATE_W'($urandom);
                1: rate = RATE_W'($urandom_range(1, 192000));
                default: rate = RATE_W'(rate_picks[$urandom_range(0, 3)]);
            endcase
            apply_settings(LOG2_W'(log2_plan[p]), thr, rate);
            k = eff_size_log2();
            half = 1 << (k - 1);

            for (int i = 0; i < 145; i++) begin
                // Once mid-run, let the pipe run dry before going on.
                if (p == 4 && i == 70) begin
                    wait_for_drain();
                end

                pick = $urandom_range(0, 99);
                if (pick < 12) begin
                    idx = '0;
                end else if (pick < 80 && half > 1) begin
                    idx = IDX_W'($urandom_range(1, half - 1));
                end else if (pick < 88) begin
                    idx = IDX_W'($urandom_range(half, half + 2));
                end else begin
                    idx = IDX_W'($urandom);
                end

                target = (idx == '0) ? longint'(cur_thr) : (longint'(cur_thr) << k);
                case ($urandom_range(0, 3))
                    0: begin
                        a = longint'($urandom_range(0, 24'hFFFFFF)) + SMP_MIN;
                        b = longint'($urandom_range(0, 24'hFFFFFF)) + SMP_MIN;
                    end
                    1: begin
                        a = longint'($urandom_range(0, 127)) - 64;
                        b = longint'($urandom_range(0, 127)) - 64;
                    end
                    2: begin
                        // straddle the threshold by a couple of units
                        a = target + longint'($urandom_range(0, 4)) - 2;
                        if (idx != '0 && $urandom_range(0, 1) == 1) begin
                            a = -a;
                        end
                        b = longint'($urandom_range(0, 2)) - 1;
                    end
                    default: begin
                        a = ($urandom_range(0, 1) == 1) ? SMP_MAX : SMP_MIN;
                        b = longint'($urandom_range(0, 24'hFFFFFF)) + SMP_MIN;
                    end
                endcase
                send_bin(idx, clip_sample(a), clip_sample(b));
            end
        end
    endtask

    // Compare every strobed line against the oldest prediction.
    always @(posedge i_clk) begin
        t_spectral_line want;
        if (i_rst_n && o_result_valid === 1'b1) begin
            if (expected_lines.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected line: expected none, actual freq %0d amp %0d dc %0d",
                         $time, o_frequency, o_amplitude, o_is_dc);
            end else begin
                want = expected_lines.pop_front();
                lines_checked++;
                if (o_frequency !== want.freq) begin
                    mismatches++;
                    $display("%0t: frequency: expected %0d actual %0d",
                             $time, want.freq, o_frequency);
                end
                if (o_amplitude !== want.amp) begin
                    mismatches++;
                    $display("%0t: amplitude: expected %0d actual %0d",
                             $time, want.amp, o_amplitude);
                end
                if (o_is_dc !== want.dc) begin
                    mismatches++;
                    $display("%0t: is_dc: expected %0d actual %0d",
                             $time, want.dc, o_is_dc);
                end
            end
        end
    end

    // Watchdog: far beyond the slowest legal run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d lines outstanding",
                     $time, expected_lines.size());
            $display("tb_fft_bin_amplitude_extractor: errors");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_band_edges();
        test_config_extremes();
        test_random_sweep();

        settle_pipeline();
        $display("Sent %0d bins under %0d register settings (sizes 2..4096 and clamped,",
                 bins_sent, settings_applied + 1);
        $display("zero/huge thresholds, zero/top rates); %0d reported lines checked.",
                 lines_checked);
        if (mismatches == 0) begin
            $display("tb_fft_bin_amplitude_extractor: clean");
        end else begin
            $display("tb_fft_bin_amplitude_extractor: errors");
        end
        $finish;
    end

endmodule
